>>> design/hpte_pkg.sv
// Shared types, constants and name-matching functions for the HTML paragraph
// text extractor. No dependencies; every other design file uses this package.
`default_nettype none

package hpte_pkg;

  // Default sizes handed to the top level parameters
  localparam int ENTITY_SPAN_DEF  = 8;
  localparam int TAG_NAME_MAX_DEF = 10;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Results beyond this count for one request are dropped
  localparam int MAX_RESULTS = 12;

  // Name compare window: longest block name is ten bytes
  localparam int NAME_BYTES = 10;
  localparam int NAME_W     = 5;

  // Request commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  // Character codes
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Input request and result payloads
  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
    logic       head_mark;
    logic       last;
  } out_item_t;

  // Work handed from the front to the back
  typedef enum logic {
    OP_FEED,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       space;
    logic [7:0] ch;
    logic       heading;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Compare the first len bytes of nm (byte 0 in the low bits) against the
  // n-byte string s (first character in the high bits)
  function automatic logic name_is(input logic [8*NAME_BYTES-1:0] nm,
                                   input logic [NAME_W-1:0] len,
                                   input logic [8*NAME_BYTES-1:0] s,
                                   input int n);
    logic ok;
    int   k;
    ok = (len == NAME_W'(n));
    for (int i = 0; i < NAME_BYTES; i++) begin
      k = (i < n) ? 8 * (n - 1 - i) : 0;
      if (i < n && nm[8*i +: 8] != s[k +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  // Block-level tag names that end a paragraph
  function automatic logic is_block_name(input logic [8*NAME_BYTES-1:0] nm,
                                         input logic [NAME_W-1:0] len);
    return name_is(nm, len, "p", 1)  || name_is(nm, len, "div", 3) ||
           name_is(nm, len, "h1", 2) || name_is(nm, len, "h2", 2)  ||
           name_is(nm, len, "h3", 2) || name_is(nm, len, "h4", 2)  ||
           name_is(nm, len, "h5", 2) || name_is(nm, len, "h6", 2)  ||
           name_is(nm, len, "li", 2) || name_is(nm, len, "blockquote", 10) ||
           name_is(nm, len, "pre", 3) || name_is(nm, len, "hr", 2) ||
           name_is(nm, len, "br", 2) || name_is(nm, len, "section", 7) ||
           name_is(nm, len, "article", 7) || name_is(nm, len, "header", 6) ||
           name_is(nm, len, "footer", 6) || name_is(nm, len, "tr", 2);
  endfunction

  // Named entity lookup: {hit, decoded byte}
  function automatic logic [8:0] ent_lookup(input logic [8*NAME_BYTES-1:0] nm,
                                            input logic [NAME_W-1:0] len);
    logic [8:0] r;
    r = '0;
    if (name_is(nm, len, "amp", 3))  r = {1'b1, CH_AMP};
    if (name_is(nm, len, "lt", 2))   r = {1'b1, CH_LT};
    if (name_is(nm, len, "gt", 2))   r = {1'b1, CH_GT};
    if (name_is(nm, len, "quot", 4)) r = {1'b1, CH_QUOT};
    if (name_is(nm, len, "apos", 4)) r = {1'b1, CH_APOS};
    if (name_is(nm, len, "nbsp", 4)) r = {1'b1, CH_SPACE};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/html_paragraph_text_extractor.sv
// Throughput: markup and whitespace bytes 1 per cycle while the work queue has room;
// each text byte and each paragraph flush becomes a work entry, and the back end takes
// a new entry only once it has finished the previous one.
// Reset: synchronous, active low; clears parser, queue and output state.
// Top level: front parser, work queue and entity/flush back end. Uses hpte_pkg.
`default_nettype none

module html_paragraph_text_extractor #(
  parameter int ENTITY_SPAN  = hpte_pkg::ENTITY_SPAN_DEF,
  parameter int TAG_NAME_MAX = hpte_pkg::TAG_NAME_MAX_DEF,
  parameter int QUEUE_DEPTH  = hpte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hpte_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hpte_pkg::out_item_t out_data
);

  logic                in_accept;
  logic                push;
  hpte_pkg::work_t     push_data;
  logic                pop;
  hpte_pkg::work_t     pop_data;
  hpte_pkg::q_status_t qs;

  // Hold the sender while the queue is full
  assign in_stall  = qs.full;
  assign in_accept = in_valid && !in_stall;

  hpte_front #(
    .TAG_NAME_MAX(TAG_NAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_data),
    .push     (push),
    .push_data(push_data)
  );

  hpte_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (qs)
  );

  hpte_back #(
    .ENTITY_SPAN(ENTITY_SPAN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qs       (qs),
    .work     (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> design/hpte_front.sv
// Front end: parses markup, collects tag names, collapses whitespace and
// turns each request into at most one work entry. Depends on hpte_pkg.
`default_nettype none

module hpte_front #(
  parameter int TAG_NAME_MAX = hpte_pkg::TAG_NAME_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  hpte_pkg::in_item_t item,
  output logic               push,
  output hpte_pkg::work_t    push_data
);

  localparam int LEN_W = $clog2(TAG_NAME_MAX + 1);

  typedef enum logic [1:0] {
    M_TEXT,
    M_TAG,
    M_SKIP
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [7:0]       store_r [TAG_NAME_MAX];
  logic [7:0]       store_nxt [TAG_NAME_MAX];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             first_r, first_nxt;
  logic             closing_r, closing_nxt;
  logic             ended_r, ended_nxt;
  logic             over_r, over_nxt;
  logic             has_text_r, has_text_nxt;
  logic             pend_r, pend_nxt;
  logic             head_r, head_nxt;

  logic [8*hpte_pkg::NAME_BYTES-1:0] name_vec;
  logic             is_blk;
  logic             is_hd;

  // Gather the tag name for the block-name compare
  always_comb begin
    for (int k = 0; k < hpte_pkg::NAME_BYTES; k++) begin
      name_vec[8*k +: 8] = store_r[k];
    end
    is_blk = !over_r && hpte_pkg::is_block_name(name_vec, hpte_pkg::NAME_W'(len_r));
    is_hd  = (len_r == LEN_W'(2)) && (store_r[0] == hpte_pkg::CH_LO_H) &&
             (store_r[1] >= hpte_pkg::CH_ONE) && (store_r[1] <= hpte_pkg::CH_SIX);
  end

  // Classify the request and update the parser state
  always_comb begin
    logic [7:0] c;
    logic [7:0] lc;
    logic       do_flush;
    logic       set_head;
    logic       name_in;
    c        = item.in_byte;
    lc       = (c >= hpte_pkg::CH_UP_A && c <= hpte_pkg::CH_UP_Z) ?
               c + hpte_pkg::CASE_OFS : c;
    do_flush = 1'b0;
    set_head = 1'b0;
    name_in  = 1'b0;

    mode_nxt     = mode_r;
    store_nxt    = store_r;
    len_nxt      = len_r;
    first_nxt    = first_r;
    closing_nxt  = closing_r;
    ended_nxt    = ended_r;
    over_nxt     = over_r;
    has_text_nxt = has_text_r;
    pend_nxt     = pend_r;
    head_nxt     = head_r;

    push              = 1'b0;
    push_data.op      = hpte_pkg::OP_FEED;
    push_data.space   = pend_r;
    push_data.ch      = c;
    push_data.heading = head_r;

    if (accept) begin
      if (item.command == hpte_pkg::CMD_END) begin
        mode_nxt    = M_TEXT;
        len_nxt     = '0;
        first_nxt   = 1'b0;
        closing_nxt = 1'b0;
        ended_nxt   = 1'b0;
        over_nxt    = 1'b0;
        do_flush    = 1'b1;
      end else begin
        case (mode_r)
          M_TAG: begin
            if (c == hpte_pkg::CH_GT) begin
              if (is_blk) begin
                do_flush = 1'b1;
                set_head = is_hd && !closing_r;
              end
              mode_nxt = M_TEXT;
            end else if (first_r) begin
              first_nxt = 1'b0;
              if (c == hpte_pkg::CH_BANG || c == hpte_pkg::CH_QUEST) begin
                mode_nxt = M_SKIP;
              end else if (c == hpte_pkg::CH_SLASH) begin
                closing_nxt = 1'b1;
              end else begin
                name_in = 1'b1;
              end
            end else begin
              name_in = 1'b1;
            end
          end
          M_SKIP: begin
            if (c == hpte_pkg::CH_GT) mode_nxt = M_TEXT;
          end
          default: begin
            if (c == hpte_pkg::CH_LT) begin
              mode_nxt    = M_TAG;
              len_nxt     = '0;
              first_nxt   = 1'b1;
              closing_nxt = 1'b0;
              ended_nxt   = 1'b0;
              over_nxt    = 1'b0;
            end else if (c == hpte_pkg::CH_SPACE || c == hpte_pkg::CH_TAB ||
                         c == hpte_pkg::CH_CR || c == hpte_pkg::CH_LF) begin
              if (has_text_r) pend_nxt = 1'b1;
            end else begin
              push         = 1'b1;
              pend_nxt     = 1'b0;
              has_text_nxt = 1'b1;
            end
          end
        endcase
      end
    end

    // Collect one tag-name byte
    if (name_in && !ended_r) begin
      if (c == hpte_pkg::CH_SPACE || c == hpte_pkg::CH_TAB || c == hpte_pkg::CH_SLASH) begin
        ended_nxt = 1'b1;
      end else if (len_r < LEN_W'(TAG_NAME_MAX)) begin
        for (int k = 0; k < TAG_NAME_MAX; k++) begin
          if (LEN_W'(k) == len_r) store_nxt[k] = lc;
        end
        len_nxt = len_r + LEN_W'(1);
      end else begin
        over_nxt = 1'b1;
      end
    end

    // Close the paragraph; only a paragraph with text leaves work behind
    if (do_flush) begin
      if (has_text_r) begin
        push         = 1'b1;
        push_data.op = hpte_pkg::OP_FLUSH;
      end
      has_text_nxt = 1'b0;
      pend_nxt     = 1'b0;
      head_nxt     = set_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_TEXT;
      len_r      <= '0;
      first_r    <= 1'b0;
      closing_r  <= 1'b0;
      ended_r    <= 1'b0;
      over_r     <= 1'b0;
      has_text_r <= 1'b0;
      pend_r     <= 1'b0;
      head_r     <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      len_r      <= len_nxt;
      first_r    <= first_nxt;
      closing_r  <= closing_nxt;
      ended_r    <= ended_nxt;
      over_r     <= over_nxt;
      has_text_r <= has_text_nxt;
      pend_r     <= pend_nxt;
      head_r     <= head_nxt;
    end
    store_r <= store_nxt;
  end

endmodule

`default_nettype wire

>>> design/hpte_queue.sv
// Short work queue between the front end and the back end.
// Depends on hpte_pkg for the entry and status types.
`default_nettype none

module hpte_queue #(
  parameter int DEPTH = hpte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hpte_pkg::work_t     push_data,
  input  logic                pop,
  output hpte_pkg::work_t     pop_data,
  output hpte_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hpte_pkg::work_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign pop_data     = mem_r[rd_r];
  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    if (pop)  rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (!push && pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

>>> design/hpte_back.sv
// Back end: entity window, replay of failed entities, paragraph flush and the
// result staging that marks the last result of each request. Uses hpte_pkg.
`default_nettype none

module hpte_back #(
  parameter int ENTITY_SPAN = hpte_pkg::ENTITY_SPAN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpte_pkg::q_status_t qs,
  input  hpte_pkg::work_t     work,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hpte_pkg::out_item_t out_data
);

  localparam int PQ_DEPTH = ENTITY_SPAN + 1;
  localparam int PQ_W     = $clog2(PQ_DEPTH + 1);
  localparam int WC_W     = $clog2(ENTITY_SPAN + 1);
  localparam int RC_W     = $clog2(hpte_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DUMP,
    B_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          pq_r [PQ_DEPTH];
  logic [7:0]          pq_nxt [PQ_DEPTH];
  logic [PQ_W-1:0]     pq_len_r, pq_len_nxt;
  logic [7:0]          win_r [ENTITY_SPAN];
  logic [7:0]          win_nxt [ENTITY_SPAN];
  logic [WC_W-1:0]     win_cnt_r, win_cnt_nxt;
  logic                tail_mark_r, tail_mark_nxt;
  logic                head_r, head_nxt;
  logic [RC_W-1:0]     rc_r, rc_nxt;
  hpte_pkg::out_item_t hold_r, hold_nxt;
  logic                hold_vld_r, hold_vld_nxt;
  hpte_pkg::out_item_t out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    logic [7:0]                        c;
    logic                              go;
    logic                              emit_req;
    logic                              emit_kind;
    logic [7:0]                        emit_byte;
    logic [8*hpte_pkg::NAME_BYTES-1:0] ent_nm;
    logic [8:0]                        ent;
    c         = pq_r[0];
    go        = !out_vld_r || !out_stall;
    emit_req  = 1'b0;
    emit_kind = hpte_pkg::KIND_TEXT;
    emit_byte = '0;
    ent_nm    = '0;
    for (int k = 0; k < 4; k++) ent_nm[8*k +: 8] = win_r[k + 1];
    ent = hpte_pkg::ent_lookup(ent_nm,
                               hpte_pkg::NAME_W'(win_cnt_r) - hpte_pkg::NAME_W'(1));

    state_nxt     = state_r;
    pq_nxt        = pq_r;
    pq_len_nxt    = pq_len_r;
    win_nxt       = win_r;
    win_cnt_nxt   = win_cnt_r;
    tail_mark_nxt = tail_mark_r;
    head_nxt      = head_r;
    rc_nxt        = rc_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r;
    pop           = 1'b0;

    // Drop the output once taken
    if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;

    case (state_r)
      // Take the next work entry
      B_IDLE: begin
        if (!qs.empty) begin
          pop      = 1'b1;
          head_nxt = work.heading;
          rc_nxt   = '0;
          if (work.op == hpte_pkg::OP_FLUSH) begin
            tail_mark_nxt = 1'b1;
            state_nxt     = B_DUMP;
          end else begin
            pq_nxt[0]  = work.space ? hpte_pkg::CH_SPACE : work.ch;
            pq_nxt[1]  = work.ch;
            pq_len_nxt = work.space ? PQ_W'(2) : PQ_W'(1);
            state_nxt  = B_RUN;
          end
        end
      end

      // Run one byte through the entity window
      B_RUN: begin
        if (go) begin
          for (int i = 0; i < PQ_DEPTH - 1; i++) pq_nxt[i] = pq_r[i + 1];
          pq_len_nxt = pq_len_r - PQ_W'(1);
          state_nxt  = (pq_len_r == PQ_W'(1)) ? B_FINISH : B_RUN;
          if (win_cnt_r == '0) begin
            if (c == hpte_pkg::CH_AMP) begin
              win_nxt[0]  = c;
              win_cnt_nxt = WC_W'(1);
            end else begin
              emit_req  = 1'b1;
              emit_byte = c;
            end
          end else if (c == hpte_pkg::CH_SEMI) begin
            if (ent[8]) begin
              emit_req    = 1'b1;
              emit_byte   = ent[7:0];
              win_cnt_nxt = '0;
            end else begin
              tail_mark_nxt = 1'b0;
              state_nxt     = B_DUMP;
            end
          end else if (win_cnt_r < WC_W'(ENTITY_SPAN)) begin
            for (int i = 0; i < ENTITY_SPAN; i++) begin
              if (WC_W'(i) == win_cnt_r) win_nxt[i] = c;
            end
            win_cnt_nxt = win_cnt_r + WC_W'(1);
          end else begin
            // Window full without ';': pass '&' and rescan the rest
            emit_req  = 1'b1;
            emit_byte = hpte_pkg::CH_AMP;
            for (int i = 0; i < ENTITY_SPAN - 1; i++) pq_nxt[i] = win_r[i + 1];
            pq_nxt[ENTITY_SPAN - 1] = c;
            pq_nxt[ENTITY_SPAN]     = pq_r[1];
            pq_len_nxt  = PQ_W'(ENTITY_SPAN) + pq_len_r - PQ_W'(1);
            win_cnt_nxt = '0;
            state_nxt   = B_RUN;
          end
        end
      end

      // Pass buffered window bytes, then ';' or the paragraph marker
      B_DUMP: begin
        if (go) begin
          emit_req = 1'b1;
          if (win_cnt_r != '0) begin
            emit_byte = win_r[0];
            for (int i = 0; i < ENTITY_SPAN - 1; i++) win_nxt[i] = win_r[i + 1];
            win_cnt_nxt = win_cnt_r - WC_W'(1);
          end else if (tail_mark_r) begin
            emit_kind = hpte_pkg::KIND_MARK;
            state_nxt = B_FINISH;
          end else begin
            emit_byte = hpte_pkg::CH_SEMI;
            state_nxt = (pq_len_r == '0) ? B_FINISH : B_RUN;
          end
        end
      end

      // Release the held result as the last one of the request
      B_FINISH: begin
        if (go) begin
          if (hold_vld_r) begin
            out_nxt      = hold_r;
            out_nxt.last = 1'b1;
            out_vld_nxt  = 1'b1;
            hold_vld_nxt = 1'b0;
          end
          state_nxt = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // Stage a new result: the previous one moves out as not last
    if (emit_req && rc_r < RC_W'(hpte_pkg::MAX_RESULTS)) begin
      if (hold_vld_r) begin
        out_nxt      = hold_r;
        out_nxt.last = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      hold_nxt.kind      = emit_kind;
      hold_nxt.text_byte = emit_byte;
      hold_nxt.head_mark = head_r;
      hold_nxt.last      = 1'b0;
      hold_vld_nxt       = 1'b1;
      rc_nxt             = rc_r + RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pq_len_r    <= '0;
      win_cnt_r   <= '0;
      tail_mark_r <= 1'b0;
      head_r      <= 1'b0;
      rc_r        <= '0;
      hold_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pq_len_r    <= pq_len_nxt;
      win_cnt_r   <= win_cnt_nxt;
      tail_mark_r <= tail_mark_nxt;
      head_r      <= head_nxt;
      rc_r        <= rc_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
    pq_r   <= pq_nxt;
    win_r  <= win_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

>>> design/hpte_checker.sv
// Port-level checks for the HTML paragraph text extractor, bound to the top.
// Depends on hpte_pkg and on html_paragraph_text_extractor.
`default_nettype none

module hpte_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire hpte_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire hpte_pkg::out_item_t out_data
);

  // Stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Paragraph marker carries a zero byte
  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == hpte_pkg::KIND_MARK |-> out_data.text_byte == 8'h00)
    else $error("paragraph marker with nonzero byte");

  // Paragraph marker closes its request
  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == hpte_pkg::KIND_MARK |-> out_data.last)
    else $error("paragraph marker not last");

endmodule

bind html_paragraph_text_extractor hpte_checker u_hpte_checker (.*);

`default_nettype wire
